// ===== hdl/nsg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the sine table for the NCO signal generator.
package nsg_pkg;

	// Phase bits that address the sine table
	localparam int TABLE_BITS = 8;

	// Width of the signed FM product: 8-bit sample times zero-extended 32-bit step
	localparam int FM_PROD_W = 41;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_ENABLE     = 3'd0,
		CFG_MODE       = 3'd1,
		CFG_SHAPE      = 3'd2,
		CFG_TONE_STEP  = 3'd3,
		CFG_FM_STEP    = 3'd4,
		CFG_DURATION   = 3'd5,
		CFG_NOISE_SEED = 3'd6
	} cfg_reg_t;

	// Modulation codes; all others hold the last I/Q pair
	typedef enum logic [3:0] {
		MOD_CW    = 4'd0,
		MOD_FM    = 4'd1,
		MOD_BPSK  = 4'd2,
		MOD_QPSK  = 4'd3,
		MOD_DSB   = 4'd4,
		MOD_AM100 = 4'd5,
		MOD_AM50  = 4'd6,
		MOD_PULSE = 4'd7
	} mod_t;

	// Modulating tone shapes; all others hold the last tone sample
	typedef enum logic [3:0] {
		SHP_SINE     = 4'd0,
		SHP_TRIANGLE = 4'd1,
		SHP_SAW_UP   = 4'd2,
		SHP_SAW_DOWN = 4'd3,
		SHP_SQUARE   = 4'd4,
		SHP_NOISE    = 4'd5
	} shape_t;

	// Sample levels
	localparam logic [7:0] AMP_POS    = 8'd127;
	localparam logic [7:0] AMP_NEG    = 8'd128;
	localparam logic [7:0] MID_OFFSET = 8'd128;
	localparam logic [7:0] AM100_BIAS = 8'd64;
	localparam logic [7:0] AM50_BIAS  = 8'd96;
	localparam logic [7:0] QUARTER_TURN = 8'd64;

	// Noise divider ticks
	localparam logic [3:0] NOISE_SHIFT_TICK = 4'd0;
	localparam logic [3:0] NOISE_MID_TICK   = 4'd5;
	localparam logic [3:0] NOISE_HIGH_TICK  = 4'd10;
	localparam logic [3:0] NOISE_DIV_WRAP   = 4'd15;

	// QPSK symbol angles, one per quadrant of the tone phase
	localparam logic [7:0] QPSK_SYMBOL [4] = '{8'd32, 8'd96, 8'd159, 8'd223};

	// Quarter sine, round(127*sin(2*pi*k/256)) for k = 0..64
	localparam logic [6:0] QUARTER_WAVE [65] = '{
		7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
		7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
		7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
		7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
		7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
		7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
		7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
		7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
		7'd127
	};

	// Configuration register file
	typedef struct packed {
		logic        enable;
		logic [3:0]  mode;
		logic [3:0]  shape;
		logic [31:0] tone_step;
		logic [31:0] fm_step;
		logic [31:0] duration;
		logic [15:0] noise_seed;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		enable: 1'b0, mode: 4'd0, shape: 4'd0, tone_step: 32'd0,
		fm_step: 32'd0, duration: 32'd0, noise_seed: 16'd1
	};

	// Per-tick state other than the tone phase
	typedef struct packed {
		logic [31:0] samples_left;
		logic [15:0] lfsr;
		logic [3:0]  divider;
		logic [7:0]  held_sample;
		logic        running;
	} ctrl_state_t;

	localparam ctrl_state_t CTRL_RESET = '{
		samples_left: 32'd0, lfsr: 16'd1, divider: 4'd0,
		held_sample: 8'd0, running: 1'b0
	};

	// Result of the state update stage, carried down the pipeline
	typedef struct packed {
		logic       active;
		logic       finished;
		logic       has_new;
		logic       is_fm;
		logic [7:0] i_val;
		logic [7:0] q_val;
		logic [7:0] sample;
	} tick_res_t;

	// Full-wave sine lookup built from the quarter table
	function automatic logic [7:0] sine_rom(input logic [7:0] k);
		logic [6:0] idx;
		logic [7:0] mag;
		begin
			if (k[6]) begin
				idx = 7'(8'd128 - {1'b0, k[6:0]});
			end else begin
				idx = {1'b0, k[5:0]};
			end
			mag = {1'b0, QUARTER_WAVE[idx]};
			sine_rom = k[7] ? (8'd0 - mag) : mag;
		end
	endfunction

endpackage

// ===== hdl/nsg_state_ram.sv =====
`timescale 1ns / 1ps
// Single-entry state memory with registered read and write-to-read forwarding.
module nsg_state_ram #(
	parameter int WIDTH = 32,
	parameter logic [WIDTH-1:0] RESET_VALUE = '0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic [WIDTH-1:0] cur_data
);

	logic [WIDTH-1:0] mem_q [1];
	logic [WIDTH-1:0] rd_q;
	logic [WIDTH-1:0] wr_data_q;
	logic             fwd_q;

	// Storage: write and registered read (read sees the old entry)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_q[0] <= RESET_VALUE;
			rd_q     <= RESET_VALUE;
		end else begin
			rd_q <= mem_q[0];
			if (wr_en) begin
				mem_q[0] <= wr_data;
			end
		end
	end

	// Forwarding register covers a write made at the previous edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wr_data_q <= wr_data;
		end
	end

	assign cur_data = fwd_q ? wr_data_q : rd_q;

endmodule

// ===== hdl/nsg_tick_logic.sv =====
`timescale 1ns / 1ps
// Per-tick state update: budget, tone phase, tone shapes, noise and I/Q for most modes.
module nsg_tick_logic #(
	parameter int PHASE_WIDTH = 32
) (
	input  nsg_pkg::cfg_t            cfg,
	input  logic                     restart,
	input  logic [PHASE_WIDTH-1:0]   cur_phase,
	input  nsg_pkg::ctrl_state_t     cur_ctrl,
	output logic [PHASE_WIDTH-1:0]   next_phase,
	output nsg_pkg::ctrl_state_t     next_ctrl,
	output nsg_pkg::tick_res_t       res
);

	localparam int TB = nsg_pkg::TABLE_BITS;

	logic [TB-1:0]          top;
	logic [PHASE_WIDTH-1:0] step;
	logic [PHASE_WIDTH-1:0] phase_adv;
	logic                   run;
	logic [7:0]             qk;
	logic [7:0]             dbl;
	logic signed [7:0]      s;
	logic [15:0]            lfsr_now;
	logic                   fb;
	logic [3:0]             nd;

	assign top       = cur_phase[PHASE_WIDTH-1 -: TB];
	assign step      = PHASE_WIDTH'(cfg.tone_step);
	assign phase_adv = cur_phase + step;
	assign dbl       = {top[6:0], 1'b0};
	assign qk        = nsg_pkg::QPSK_SYMBOL[top[7:6]];

	always_comb begin
		next_ctrl  = cur_ctrl;
		next_phase = cur_phase;
		res        = '0;
		s          = '0;
		lfsr_now   = '0;
		fb         = 1'b0;
		nd         = '0;

		// Enable gates running; restart reloads budget and noise seed
		run = cfg.enable & cur_ctrl.running;
		if (cfg.enable && restart) begin
			next_ctrl.samples_left = cfg.duration;
			next_ctrl.lfsr         = cfg.noise_seed;
			run                    = 1'b1;
		end
		next_ctrl.running = run;

		if (run) begin
			res.active = 1'b1;

			// Sample budget
			if (next_ctrl.samples_left == 32'd0 && cfg.duration != 32'd0) begin
				next_ctrl.running = 1'b0;
				res.finished      = 1'b1;
			end else begin
				next_ctrl.samples_left = next_ctrl.samples_left - 32'd1;
			end

			unique case (cfg.mode)
				nsg_pkg::MOD_CW: begin
					res.has_new = 1'b1;
					res.i_val   = nsg_pkg::AMP_POS;
				end
				nsg_pkg::MOD_BPSK: begin
					res.has_new = 1'b1;
					res.i_val   = top[7] ? nsg_pkg::AMP_POS : nsg_pkg::AMP_NEG;
					next_phase  = phase_adv;
				end
				nsg_pkg::MOD_QPSK: begin
					res.has_new = 1'b1;
					res.i_val   = nsg_pkg::sine_rom(qk);
					res.q_val   = nsg_pkg::sine_rom(qk + nsg_pkg::QUARTER_TURN);
					next_phase  = phase_adv;
				end
				nsg_pkg::MOD_PULSE: begin
					res.has_new = 1'b1;
					res.i_val   = (top[7:6] == 2'b00) ? nsg_pkg::AMP_POS : 8'd0;
					next_phase  = phase_adv;
				end
				default: begin
					// Modulating tone sample
					unique case (cfg.shape)
						nsg_pkg::SHP_SINE: next_ctrl.held_sample = nsg_pkg::sine_rom(top);
						nsg_pkg::SHP_TRIANGLE: begin
							next_ctrl.held_sample = top[7] ? ((~dbl) + nsg_pkg::MID_OFFSET)
							                                : (dbl + nsg_pkg::MID_OFFSET);
						end
						nsg_pkg::SHP_SAW_UP:   next_ctrl.held_sample = top;
						nsg_pkg::SHP_SAW_DOWN: next_ctrl.held_sample = ~top;
						nsg_pkg::SHP_SQUARE: begin
							next_ctrl.held_sample = top[7] ? nsg_pkg::AMP_POS : nsg_pkg::AMP_NEG;
						end
						nsg_pkg::SHP_NOISE: begin
							lfsr_now = next_ctrl.lfsr;
							if (cur_ctrl.divider == nsg_pkg::NOISE_SHIFT_TICK) begin
								fb = lfsr_now[0] ^ lfsr_now[1] ^ lfsr_now[3] ^ lfsr_now[4]
								   ^ lfsr_now[12];
								next_ctrl.lfsr        = {fb, lfsr_now[15:1]};
								next_ctrl.held_sample = lfsr_now[8:1];
							end
							if (cur_ctrl.divider == nsg_pkg::NOISE_MID_TICK) begin
								next_ctrl.held_sample = lfsr_now[11:4];
							end
							if (cur_ctrl.divider == nsg_pkg::NOISE_HIGH_TICK) begin
								next_ctrl.held_sample = lfsr_now[12:5];
							end
							nd = cur_ctrl.divider + 4'd1;
							next_ctrl.divider = (nd == nsg_pkg::NOISE_DIV_WRAP) ? 4'd0 : nd;
						end
						default: ;
					endcase
					if (cfg.shape != nsg_pkg::SHP_NOISE) begin
						next_phase = phase_adv;
					end

					// Apply the tone per modulation
					s = $signed(next_ctrl.held_sample);
					if (cfg.mode == nsg_pkg::MOD_FM) begin
						res.is_fm  = 1'b1;
						res.sample = next_ctrl.held_sample;
					end else if (cfg.mode == nsg_pkg::MOD_DSB) begin
						res.has_new = 1'b1;
						res.i_val   = next_ctrl.held_sample;
					end else if (cfg.mode == nsg_pkg::MOD_AM100) begin
						res.has_new = 1'b1;
						res.i_val   = nsg_pkg::AM100_BIAS + 8'(s >>> 1);
					end else if (cfg.mode == nsg_pkg::MOD_AM50) begin
						res.has_new = 1'b1;
						res.i_val   = nsg_pkg::AM50_BIAS + 8'(s >>> 2);
					end
				end
			endcase
		end
	end

endmodule

// ===== hdl/nco_signal_generator_unit.sv =====
`timescale 1ns / 1ps
// Top level of the NCO signal generator: config registers, pipeline and output stage.
// One sample tick is accepted per clock while in_ready is high, and its I/Q pair passes
// through stages 1 to 4 into the output register. The rate is set by the read-modify-write
// of the tick state memory (tone phase, budget, noise LFSR) in stage 1, and of the FM
// carrier phase memory in stage 3, both with forwarding so consecutive ticks see each
// other's updates. Stage 2 holds the FM multiply, stage 4 the carrier sine lookup.
// Configuration must be written only while idle; the block itself does not enforce it.
module nco_signal_generator_unit #(
	parameter int PHASE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write port
	input  logic              cfg_write,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	// tick input
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              restart,
	// sample output
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] i_sample,
	output logic signed [7:0] q_sample,
	output logic              active,
	output logic              finished
);

	localparam int TB      = nsg_pkg::TABLE_BITS;
	localparam int CTRL_W  = $bits(nsg_pkg::ctrl_state_t);
	localparam int STATE_W = PHASE_WIDTH + CTRL_W;
	localparam logic [STATE_W-1:0] STATE_RESET = {{PHASE_WIDTH{1'b0}}, nsg_pkg::CTRL_RESET};

	nsg_pkg::cfg_t cfg_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= nsg_pkg::CFG_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				nsg_pkg::CFG_ENABLE:     cfg_q.enable     <= cfg_data[0];
				nsg_pkg::CFG_MODE:       cfg_q.mode       <= cfg_data[3:0];
				nsg_pkg::CFG_SHAPE:      cfg_q.shape      <= cfg_data[3:0];
				nsg_pkg::CFG_TONE_STEP:  cfg_q.tone_step  <= cfg_data;
				nsg_pkg::CFG_FM_STEP:    cfg_q.fm_step    <= cfg_data;
				nsg_pkg::CFG_DURATION:   cfg_q.duration   <= cfg_data;
				nsg_pkg::CFG_NOISE_SEED: cfg_q.noise_seed <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control: a stage loads when empty or when it moves on
	logic valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_out;

	assign rdy_out  = !out_valid_q || out_ready;
	assign rdy4     = !valid_s4 || rdy_out;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)    valid_s1    <= in_valid;
			if (rdy2)    valid_s2    <= valid_s1;
			if (rdy3)    valid_s3    <= valid_s2;
			if (rdy4)    valid_s4    <= valid_s3;
			if (rdy_out) out_valid_q <= valid_s4;
		end
	end

	// Stage 1: tick state read-modify-write
	logic                   restart_s1;
	logic [STATE_W-1:0]     state_cur;
	logic [STATE_W-1:0]     state_nxt;
	logic [PHASE_WIDTH-1:0] phase_nxt;
	nsg_pkg::ctrl_state_t   ctrl_nxt;
	nsg_pkg::tick_res_t     res_s1;
	logic                   state_we;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			restart_s1 <= restart;
		end
	end

	assign state_we  = valid_s1 && rdy2;
	assign state_nxt = {phase_nxt, ctrl_nxt};

	nsg_state_ram #(
		.WIDTH       (STATE_W),
		.RESET_VALUE (STATE_RESET)
	) u_tick_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (state_we),
		.wr_data  (state_nxt),
		.cur_data (state_cur)
	);

	nsg_tick_logic #(
		.PHASE_WIDTH (PHASE_WIDTH)
	) u_tick (
		.cfg        (cfg_q),
		.restart    (restart_s1),
		.cur_phase  (state_cur[STATE_W-1 -: PHASE_WIDTH]),
		.cur_ctrl   (nsg_pkg::ctrl_state_t'(state_cur[CTRL_W-1:0])),
		.next_phase (phase_nxt),
		.next_ctrl  (ctrl_nxt),
		.res        (res_s1)
	);

	// Stage 2: FM deviation multiply
	nsg_pkg::tick_res_t res_s2;
	logic signed [nsg_pkg::FM_PROD_W-1:0] fm_prod;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			res_s2 <= res_s1;
		end
	end

	assign fm_prod = $signed(res_s2.sample) * $signed({1'b0, cfg_q.fm_step});

	// Stage 3: carrier phase read-modify-write
	nsg_pkg::tick_res_t     res_s3;
	logic [PHASE_WIDTH-1:0] prod_s3;
	logic [PHASE_WIDTH-1:0] carrier_cur;
	logic [PHASE_WIDTH-1:0] carrier_nxt;
	logic                   carrier_we;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			res_s3  <= res_s2;
			prod_s3 <= PHASE_WIDTH'(fm_prod);
		end
	end

	assign carrier_nxt = carrier_cur + prod_s3;
	assign carrier_we  = valid_s3 && rdy4 && res_s3.is_fm;

	nsg_state_ram #(
		.WIDTH       (PHASE_WIDTH),
		.RESET_VALUE ('0)
	) u_carrier_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (carrier_we),
		.wr_data  (carrier_nxt),
		.cur_data (carrier_cur)
	);

	// Stage 4: carrier sine lookup and held I/Q selection
	nsg_pkg::tick_res_t res_s4;
	logic [TB-1:0]      car_top_s4;
	logic [7:0]         sel_i, sel_q;
	logic               upd_held;
	logic [7:0]         held_i_q, held_q_q;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			res_s4     <= res_s3;
			car_top_s4 <= carrier_nxt[PHASE_WIDTH-1 -: TB];
		end
	end

	always_comb begin
		upd_held = 1'b0;
		sel_i    = held_i_q;
		sel_q    = held_q_q;
		if (!res_s4.active) begin
			sel_i = 8'd0;
			sel_q = 8'd0;
		end else if (res_s4.is_fm) begin
			upd_held = 1'b1;
			sel_i    = nsg_pkg::sine_rom(car_top_s4 + nsg_pkg::QUARTER_TURN);
			sel_q    = nsg_pkg::sine_rom(car_top_s4);
		end else if (res_s4.has_new) begin
			upd_held = 1'b1;
			sel_i    = res_s4.i_val;
			sel_q    = res_s4.q_val;
		end
	end

	// Held I/Q for undefined modulation codes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_i_q <= 8'd0;
			held_q_q <= 8'd0;
		end else if (valid_s4 && rdy_out && upd_held) begin
			held_i_q <= sel_i;
			held_q_q <= sel_q;
		end
	end

	// Output register
	logic [7:0] i_q, q_q;
	logic       active_q, finished_q;

	always_ff @(posedge clk) begin
		if (rdy_out && valid_s4) begin
			i_q        <= sel_i;
			q_q        <= sel_q;
			active_q   <= res_s4.active;
			finished_q <= res_s4.finished;
		end
	end

	assign out_valid = out_valid_q;
	assign i_sample  = $signed(i_q);
	assign q_sample  = $signed(q_q);
	assign active    = active_q;
	assign finished  = finished_q;

	// An idle tick carries zero samples
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !active_q |-> (i_q == 8'd0) && (q_q == 8'd0))
		else $error("idle transaction with nonzero sample");

	// Budget end is only flagged on a generated sample
	a_fin_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && finished_q |-> active_q)
		else $error("finished without active");

	// Carrier phase only moves for FM ticks
	a_carrier_fm: assert property (@(posedge clk) disable iff (!arst_n)
		carrier_we |-> (cfg_q.mode == nsg_pkg::MOD_FM))
		else $error("carrier update outside FM mode");

	// A disabled generator produces no active tick
	a_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !cfg_q.enable |-> !res_s1.active)
		else $error("active tick while disabled");

	// A state write is forwarded to the next tick
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		state_we |=> (state_cur == $past(state_nxt)))
		else $error("tick state not forwarded");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the NCO signal generator: predicts every I/Q sample and compares.
module tb_top;

	// Codes outside the defined sets, used to exercise the hold behavior
	localparam logic [3:0] MOD_UNDEF = 4'd9;
	localparam logic [3:0] SHP_UNDEF = 4'd12;
	localparam logic [3:0] CODE_MAX  = 4'hF;

	localparam int RANDOM_TICKS = 700;
	localparam int CYCLE_LIMIT  = 400000;

	// One expected output transaction
	typedef struct packed {
		logic [7:0] i_val;
		logic [7:0] q_val;
		logic       act;
		logic       fin;
	} gen_sample_t;

	// Generator predictor plus the queue of samples still owed by the block
	class sample_scoreboard;
		logic        en;
		logic [3:0]  mode;
		logic [3:0]  shape;
		logic [31:0] tone_step;
		logic [31:0] fm_step;
		logic [31:0] duration;
		logic [15:0] seed;
		logic [31:0] tone_acc;
		logic [31:0] carrier_phase;
		logic [31:0] samples_left;
		logic [15:0] lfsr;
		logic [3:0]  divider;
		logic [7:0]  held_sample;
		logic [7:0]  held_i;
		logic [7:0]  held_q;
		bit          running;
		gen_sample_t owed_samples[$];
		int          errors;
		int          checked;
		int          live;
		int          budget_ends;

		function new();
			en = nsg_pkg::CFG_RESET.enable;
			mode = nsg_pkg::CFG_RESET.mode;
			shape = nsg_pkg::CFG_RESET.shape;
			tone_step = nsg_pkg::CFG_RESET.tone_step;
			fm_step = nsg_pkg::CFG_RESET.fm_step;
			duration = nsg_pkg::CFG_RESET.duration;
			seed = nsg_pkg::CFG_RESET.noise_seed;
			tone_acc = '0;
			carrier_phase = '0;
			samples_left = '0;
			lfsr = 16'd1;
			divider = '0;
			held_sample = '0;
			held_i = '0;
			held_q = '0;
			running = 1'b0;
			errors = 0;
			checked = 0;
			live = 0;
			budget_ends = 0;
		endfunction

		function void set_reg(nsg_pkg::cfg_reg_t idx, logic [31:0] val);
			case (idx)
				nsg_pkg::CFG_ENABLE:     en = val[0];
				nsg_pkg::CFG_MODE:       mode = val[3:0];
				nsg_pkg::CFG_SHAPE:      shape = val[3:0];
				nsg_pkg::CFG_TONE_STEP:  tone_step = val;
				nsg_pkg::CFG_FM_STEP:    fm_step = val;
				nsg_pkg::CFG_DURATION:   duration = val;
				nsg_pkg::CFG_NOISE_SEED: seed = val[15:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return owed_samples.size();
		endfunction

		// Full-wave sine built by folding the quarter table
		function logic [7:0] sine_at(logic [7:0] k);
			int kk;
			int m;
			kk = k;
			if (kk < 64) m = nsg_pkg::QUARTER_WAVE[kk];
			else if (kk < 128) m = nsg_pkg::QUARTER_WAVE[128 - kk];
			else if (kk < 192) m = -int'(nsg_pkg::QUARTER_WAVE[kk - 128]);
			else m = -int'(nsg_pkg::QUARTER_WAVE[256 - kk]);
			return 8'(m);
		endfunction

		// Modulating tone sample; noise runs off its own divider instead of the phase
		function void next_tone_sample();
			logic [7:0] b;
			logic [7:0] t;
			logic       fb;
			b = tone_acc[31:24];
			t = {b[6:0], 1'b0};
			case (shape)
				nsg_pkg::SHP_SINE:     held_sample = sine_at(b);
				nsg_pkg::SHP_TRIANGLE: held_sample = b[7] ? (~t + 8'd128) : (t + 8'd128);
				nsg_pkg::SHP_SAW_UP:   held_sample = b;
				nsg_pkg::SHP_SAW_DOWN: held_sample = ~b;
				nsg_pkg::SHP_SQUARE:   held_sample = b[7] ? nsg_pkg::AMP_POS : nsg_pkg::AMP_NEG;
				nsg_pkg::SHP_NOISE: begin
					if (divider == nsg_pkg::NOISE_SHIFT_TICK) begin
						fb = lfsr[0] ^ lfsr[1] ^ lfsr[3] ^ lfsr[4] ^ lfsr[12];
						lfsr = {fb, lfsr[15:1]};
						held_sample = lfsr[7:0];
					end
					if (divider == nsg_pkg::NOISE_MID_TICK) held_sample = lfsr[11:4];
					if (divider == nsg_pkg::NOISE_HIGH_TICK) held_sample = lfsr[12:5];
					divider = divider + 4'd1;
					if (divider == nsg_pkg::NOISE_DIV_WRAP) divider = '0;
				end
				default: ;
			endcase
			if (shape != nsg_pkg::SHP_NOISE) tone_acc = tone_acc + tone_step;
		endfunction

		// Accepted tick: update the generator and queue the sample it must produce
		function void note_tick(logic rs);
			gen_sample_t r;
			int          s;
			logic [7:0]  sym;
			if (!en) running = 1'b0;
			if (en && rs) begin
				samples_left = duration;
				lfsr = seed;
				running = 1'b1;
			end
			if (!running) begin
				r = '0;
			end else begin
				r.fin = 1'b0;
				if (samples_left == 0 && duration != 0) begin
					running = 1'b0;
					r.fin = 1'b1;
				end else begin
					samples_left = samples_left - 32'd1;
				end
				case (mode)
					nsg_pkg::MOD_CW: begin
						held_i = nsg_pkg::AMP_POS;
						held_q = 8'd0;
					end
					nsg_pkg::MOD_BPSK: begin
						held_i = tone_acc[31] ? nsg_pkg::AMP_POS : nsg_pkg::AMP_NEG;
						held_q = 8'd0;
						tone_acc = tone_acc + tone_step;
					end
					nsg_pkg::MOD_QPSK: begin
						sym = nsg_pkg::QPSK_SYMBOL[tone_acc[31:30]];
						held_i = sine_at(sym);
						held_q = sine_at(sym + nsg_pkg::QUARTER_TURN);
						tone_acc = tone_acc + tone_step;
					end
					nsg_pkg::MOD_PULSE: begin
						held_i = (tone_acc < 32'h4000_0000) ? nsg_pkg::AMP_POS : 8'd0;
						held_q = 8'd0;
						tone_acc = tone_acc + tone_step;
					end
					default: begin
						// tone-driven modes; undefined codes run the tone but keep I/Q
						next_tone_sample();
						s = $signed(held_sample);
						case (mode)
							nsg_pkg::MOD_FM: begin
								carrier_phase = carrier_phase
									+ {{24{held_sample[7]}}, held_sample} * fm_step;
								held_i = sine_at(carrier_phase[31:24] + nsg_pkg::QUARTER_TURN);
								held_q = sine_at(carrier_phase[31:24]);
							end
							nsg_pkg::MOD_DSB: begin
								held_i = held_sample;
								held_q = 8'd0;
							end
							nsg_pkg::MOD_AM100: begin
								held_i = 8'(64 + (((s + 256) >> 1) - 128));
								held_q = 8'd0;
							end
							nsg_pkg::MOD_AM50: begin
								held_i = 8'(96 + (((s + 256) >> 2) - 64));
								held_q = 8'd0;
							end
							default: ;
						endcase
					end
				endcase
				r.i_val = held_i;
				r.q_val = held_q;
				r.act = 1'b1;
			end
			owed_samples.push_back(r);
		endfunction

		// Output transaction: compare against the oldest owed sample
		function void check_sample(logic [7:0] gi, logic [7:0] gq, logic ga, logic gf);
			gen_sample_t e;
			if (owed_samples.size() == 0) begin
				$display("%0t: unexpected sample i=%0d q=%0d active=%0b finished=%0b",
					$time, $signed(gi), $signed(gq), ga, gf);
				errors++;
				return;
			end
			e = owed_samples.pop_front();
			checked++;
			if (e.act) live++;
			if (e.fin) budget_ends++;
			if (gi !== e.i_val) begin
				$display("%0t: i_sample expected %0d got %0d", $time,
					$signed(e.i_val), $signed(gi));
				errors++;
			end
			if (gq !== e.q_val) begin
				$display("%0t: q_sample expected %0d got %0d", $time,
					$signed(e.q_val), $signed(gq));
				errors++;
			end
			if (ga !== e.act) begin
				$display("%0t: active expected %0b got %0b", $time, e.act, ga);
				errors++;
			end
			if (gf !== e.fin) begin
				$display("%0t: finished expected %0b got %0b", $time, e.fin, gf);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	nsg_pkg::cfg_reg_t cfg_index = nsg_pkg::CFG_ENABLE;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        restart = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic signed [7:0] i_sample;
	logic signed [7:0] q_sample;
	logic        active;
	logic        finished;

	sample_scoreboard sb = new();
	int  cycles = 0;
	int  ticks_sent = 0;
	int  settings = 0;
	bit  send_calm = 1'b0;
	bit  recv_calm = 1'b0;

	nco_signal_generator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.i_sample  (i_sample),
		.q_sample  (q_sample),
		.active    (active),
		.finished  (finished)
	);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d samples still owed", cycles, sb.pending());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Transaction monitors on both channels
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_tick(restart);
		if (arst_n && out_valid && out_ready) sb.check_sample(i_sample, q_sample, active, finished);
	end

	// Output side: random stall before each sample, with stretches of none
	initial begin
		int stall;
		forever begin
			if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
			stall = recv_calm ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// One tick transaction after a random gap; valid stays up across back-to-back ticks
	task automatic send_tick(input logic rs);
		int gap;
		if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rs;
		do @(posedge clk); while (!in_ready);
		ticks_sent++;
	endtask

	task automatic write_reg(input nsg_pkg::cfg_reg_t idx, input logic [31:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// Drain, reprogram every register, then send n ticks
	task automatic run_phase(input logic en, input logic [3:0] md, input logic [3:0] sh,
		input logic [31:0] ts, input logic [31:0] fs, input logic [31:0] dur,
		input logic [15:0] sd, input int n, input bit rs_first, input int rs_odds);
		logic rs;
		in_valid <= 1'b0;
		// wait on the clock first so the monitor has noted the last accepted tick
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		write_reg(nsg_pkg::CFG_ENABLE, {31'd0, en});
		write_reg(nsg_pkg::CFG_MODE, {28'd0, md});
		write_reg(nsg_pkg::CFG_SHAPE, {28'd0, sh});
		write_reg(nsg_pkg::CFG_TONE_STEP, ts);
		write_reg(nsg_pkg::CFG_FM_STEP, fs);
		write_reg(nsg_pkg::CFG_DURATION, dur);
		write_reg(nsg_pkg::CFG_NOISE_SEED, {16'd0, sd});
		cfg_write <= 1'b0;
		settings++;
		for (int k = 0; k < n; k++) begin
			rs = (k == 0) ? rs_first : (rs_odds > 0 && $urandom_range(1, rs_odds) == 1);
			send_tick(rs);
		end
	endtask

	// Random value that favors the extremes now and then
	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 4))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 32'h00FF_FFFF);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic        en;
		logic [3:0]  md;
		logic [3:0]  sh;
		logic [31:0] dur;
		logic [15:0] sd;
		int          n;
		int          random_ticks;
		random_ticks = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: idle out of reset, restart ignored while disabled
		send_tick(1'b1);
		send_tick(1'b0);
		// one-sample budget: live tick, budget end, then idle
		run_phase(1'b1, nsg_pkg::MOD_CW, nsg_pkg::SHP_SINE, 32'hFFFF_FFFF, 32'h0, 32'd1,
			16'hFFFF, 3, 1'b1, 0);
		run_phase(1'b1, nsg_pkg::MOD_BPSK, nsg_pkg::SHP_SINE, 32'h8000_0000, 32'h0, 32'd0,
			16'h0000, 2, 1'b1, 0);
		// all four QPSK quadrants
		run_phase(1'b1, nsg_pkg::MOD_QPSK, nsg_pkg::SHP_SINE, 32'h4000_0000, 32'h0,
			32'hFFFF_FFFF, 16'h0001, 4, 1'b1, 0);
		// keeps running without a restart
		run_phase(1'b1, nsg_pkg::MOD_PULSE, nsg_pkg::SHP_SINE, 32'h4000_0000, 32'h0, 32'd0,
			16'h0001, 2, 1'b0, 0);
		run_phase(1'b1, nsg_pkg::MOD_FM, nsg_pkg::SHP_NOISE, 32'h0, 32'hFFFF_FFFF, 32'd0,
			16'hACE1, 2, 1'b1, 0);
		run_phase(1'b1, nsg_pkg::MOD_DSB, nsg_pkg::SHP_TRIANGLE, 32'h9000_0000, 32'h0, 32'd0,
			16'h0001, 1, 1'b0, 0);
		run_phase(1'b1, nsg_pkg::MOD_AM100, nsg_pkg::SHP_SAW_UP, 32'hC000_0000, 32'h0, 32'd0,
			16'h0001, 1, 1'b0, 0);
		run_phase(1'b1, nsg_pkg::MOD_AM50, nsg_pkg::SHP_SAW_DOWN, 32'h3000_0000, 32'h0, 32'd0,
			16'h0001, 1, 1'b0, 0);
		run_phase(1'b1, nsg_pkg::MOD_DSB, nsg_pkg::SHP_SQUARE, 32'h8000_0000, 32'h0, 32'd0,
			16'h0001, 1, 1'b0, 0);
		// undefined modulation holds I/Q, undefined shape holds the tone sample
		run_phase(1'b1, MOD_UNDEF, nsg_pkg::SHP_SINE, 32'h1234_5678, 32'h0, 32'd0,
			16'h0001, 1, 1'b0, 0);
		run_phase(1'b1, nsg_pkg::MOD_DSB, SHP_UNDEF, 32'h1234_5678, 32'h0, 32'd0,
			16'h0001, 1, 1'b0, 0);
		// disabling stops the run; re-enabling without restart stays idle
		run_phase(1'b0, nsg_pkg::MOD_CW, nsg_pkg::SHP_SINE, 32'h0, 32'h0, 32'd0,
			16'h0001, 1, 1'b1, 0);
		run_phase(1'b1, nsg_pkg::MOD_CW, nsg_pkg::SHP_SINE, 32'h0, 32'h0, 32'd0,
			16'h0001, 1, 1'b0, 0);

		// Random settings, mostly restarted runs of defined modes
		while (random_ticks < RANDOM_TICKS) begin
			en = ($urandom_range(0, 7) != 0);
			md = ($urandom_range(0, 4) == 0) ? $urandom_range(nsg_pkg::MOD_PULSE + 1, CODE_MAX)
				: $urandom_range(nsg_pkg::MOD_CW, nsg_pkg::MOD_PULSE);
			sh = ($urandom_range(0, 4) == 0) ? $urandom_range(nsg_pkg::SHP_NOISE + 1, CODE_MAX)
				: $urandom_range(nsg_pkg::SHP_SINE, nsg_pkg::SHP_NOISE);
			case ($urandom_range(0, 7))
				0, 1, 2, 3: dur = 32'd0;
				4, 5, 6: dur = $urandom_range(1, 30);
				default: dur = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
			endcase
			case ($urandom_range(0, 5))
				0: sd = 16'h0000;
				1: sd = 16'hFFFF;
				default: sd = $urandom;
			endcase
			n = $urandom_range(4, 40);
			run_phase(en, md, sh, pick_step(), pick_step(), dur, sd, n,
				$urandom_range(0, 7) != 0, 20);
			random_ticks += n;
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		$display("Covered %0d ticks under %0d register settings across all modes and shapes.",
			ticks_sent, settings);
		$display("%0d samples compared, %0d generated, %0d budget ends, %0d mismatches.",
			sb.checked, sb.live, sb.budget_ends, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/nsg_pkg.sv
hdl/nsg_state_ram.sv
hdl/nsg_tick_logic.sv
hdl/nco_signal_generator_unit.sv
tb/tb_top.sv
